FILE: rtl/core/fpcb_pkg.sv
package fpcb_pkg;

    typedef logic [2:0][7:0] color_t;

    typedef struct packed {
        logic       func;
        logic [7:0] entry_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_item_t;

    typedef struct packed {
        logic [5:0] fog_level;
        logic [7:0] mapped_index;
        logic       last_of_run;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_PREP,
        ST_DIVIDE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_BUILD = 1'b1;

    localparam logic [1:0] REG_FOG_RED   = 2'd0;
    localparam logic [1:0] REG_FOG_GREEN = 2'd1;
    localparam logic [1:0] REG_FOG_BLUE  = 2'd2;

    localparam int CH_RED   = 2;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 0;

endpackage

FILE: rtl/core/fog_palette_column_builder_top.sv
// Palette loads raise no results, and each build yields one result per fog level.
// Each fog level forms its blend with one reciprocal multiply per channel, then scans one entry per cycle.
// The block accepts no new transaction until the last result is loaded into the output register.
// Reset is asynchronous: palette entries read as zero and the fog color returns to 128, 128, 140.
module fog_palette_column_builder_top
    import fpcb_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256,
    parameter int FOG_LEVELS      = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data,
    input  logic      cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int D       = FOG_LEVELS - 1;
    localparam int TWO_D   = 2 * D;
    localparam int NUM_MAX = TWO_D * 255 + D;
    localparam int NUM_W   = $clog2(NUM_MAX + 1);
    localparam int AW      = $clog2(PALETTE_ENTRIES);
    localparam int CW      = $clog2(PALETTE_ENTRIES + 1);
    localparam int LW      = $clog2(FOG_LEVELS);
    localparam int REC_K   = NUM_W + 7;
    localparam int REC_M   = (2 ** REC_K + TWO_D - 1) / TWO_D;
    localparam int PROD_W  = NUM_W + REC_K;

    localparam logic [NUM_W-1:0]  TWO_D_N    = NUM_W'(TWO_D);
    localparam logic [NUM_W-1:0]  D_N        = NUM_W'(D);
    localparam logic [8:0]        ENTRIES_N  = 9'(PALETTE_ENTRIES);
    localparam logic [CW-1:0]     SCAN_END   = CW'(PALETTE_ENTRIES);
    localparam logic [LW-1:0]     LAST_LEVEL = LW'(FOG_LEVELS - 1);
    localparam logic [PROD_W-1:0] REC_M_P    = PROD_W'(REC_M);

    state_t state_reg;
    state_t state_next;

    color_t fog_reg;

    color_t                     pal_mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] pal_valid_reg;
    color_t                     rd_data_reg;
    logic                       rd_ok_reg;
    logic [AW-1:0]              rd_addr;
    color_t                     pal_color;

    logic in_fire;
    logic idx_ok;
    logic load_fire;
    logic emit_go;
    logic scan_done;
    logic last_level;

    logic [NUM_W-1:0]        acc_reg    [3];
    logic signed [NUM_W:0]   delta_reg  [3];
    logic signed [NUM_W:0]   acc_sum    [3];
    logic [PROD_W-1:0]       recip_prod [3];
    color_t                  quo_calc;
    color_t                  quo_reg;

    logic [LW-1:0]  level_reg;
    logic [CW-1:0]  scan_cnt_reg;
    logic           s1_vld_reg;
    logic [AW-1:0]  s1_idx_reg;
    logic           s2_vld_reg;
    logic [AW-1:0]  s2_idx_reg;
    logic [15:0]    sq_reg [3];
    logic [7:0]     abs_diff [3];
    logic [17:0]    cand_dist;
    logic [17:0]    best_dist_reg;
    logic [AW-1:0]  best_idx_reg;

    logic      out_valid_reg;
    out_item_t out_data_reg;

    assign idx_ok     = ({1'b0, in_data.entry_index} < ENTRIES_N);
    assign in_fire    = in_valid && !in_stall;
    assign load_fire  = in_fire && (in_data.func == FUNC_LOAD) && idx_ok;
    assign last_level = (level_reg == LAST_LEVEL);
    assign emit_go    = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    assign scan_done  = (scan_cnt_reg == SCAN_END) && !s1_vld_reg && !s2_vld_reg;
    assign pal_color  = rd_ok_reg ? rd_data_reg : '0;
    assign cand_dist  = 18'(sq_reg[0]) + 18'(sq_reg[1]) + 18'(sq_reg[2]);

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            acc_sum[c]    = $signed({1'b0, acc_reg[c]}) + delta_reg[c];
            recip_prod[c] = PROD_W'(acc_reg[c]) * REC_M_P;
            quo_calc[c]   = recip_prod[c][REC_K +: 8];
            abs_diff[c]   = (pal_color[c] >= quo_reg[c]) ? (pal_color[c] - quo_reg[c])
                                                         : (quo_reg[c] - pal_color[c]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (in_data.func == FUNC_BUILD) && idx_ok)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:  state_next = ST_PREP;
            ST_PREP:   state_next = ST_DIVIDE;
            ST_DIVIDE: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    state_next = last_level ? ST_IDLE : ST_PREP;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        rd_addr  = scan_cnt_reg[AW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                rd_addr  = in_data.entry_index[AW-1:0];
            end
            ST_SETUP, ST_PREP, ST_DIVIDE, ST_SCAN, ST_EMIT:
            begin
                in_stall = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fog_reg <= {8'd128, 8'd128, 8'd140};
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FOG_RED:   fog_reg[CH_RED]   <= cfg_data;
                REG_FOG_GREEN: fog_reg[CH_GREEN] <= cfg_data;
                REG_FOG_BLUE:  fog_reg[CH_BLUE]  <= cfg_data;
                default:       fog_reg <= fog_reg;
            endcase
        end
    end

    // Entries never loaded since reset read back as zero through the valid bits.
    always_ff @(posedge clk)
    begin
        if (load_fire)
        begin
            pal_mem[in_data.entry_index[AW-1:0]] <= {in_data.red, in_data.green, in_data.blue};
        end
        rd_data_reg <= pal_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_valid_reg <= '0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            if (load_fire)
            begin
                pal_valid_reg[in_data.entry_index[AW-1:0]] <= 1'b1;
            end
            rd_ok_reg <= pal_valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= (state_reg == ST_SCAN) && (scan_cnt_reg < SCAN_END);
            s2_vld_reg <= s1_vld_reg;
            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_SETUP:
            begin
                level_reg <= '0;
                for (int c = 0; c < 3; c++)
                begin
                    acc_reg[c]   <= NUM_W'(pal_color[c]) * TWO_D_N + D_N;
                    delta_reg[c] <= $signed({{(NUM_W-8){1'b0}}, fog_reg[c], 1'b0})
                                  - $signed({{(NUM_W-8){1'b0}}, pal_color[c], 1'b0});
                end
            end
            ST_PREP:
            begin
                scan_cnt_reg  <= '0;
                best_dist_reg <= '1;
                best_idx_reg  <= '0;
            end
            ST_DIVIDE:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    quo_reg[c] <= quo_calc[c];
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg < SCAN_END)
                begin
                    scan_cnt_reg <= scan_cnt_reg + CW'(1);
                end
            end
            ST_EMIT:
            begin
                if (emit_go && !last_level)
                begin
                    level_reg <= level_reg + LW'(1);
                    for (int c = 0; c < 3; c++)
                    begin
                        acc_reg[c] <= acc_sum[c][NUM_W-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase

        s1_idx_reg <= scan_cnt_reg[AW-1:0];
        s2_idx_reg <= s1_idx_reg;
        for (int c = 0; c < 3; c++)
        begin
            sq_reg[c] <= 16'(abs_diff[c]) * 16'(abs_diff[c]);
        end

        // A strictly smaller distance is needed to move, so the lowest index wins ties.
        if (s2_vld_reg && (cand_dist < best_dist_reg))
        begin
            best_dist_reg <= cand_dist;
            best_idx_reg  <= s2_idx_reg;
        end

        if (emit_go)
        begin
            out_data_reg.fog_level    <= 6'(level_reg);
            out_data_reg.mapped_index <= 8'(best_idx_reg);
            out_data_reg.last_of_run  <= last_level;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_build_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (in_data.func == FUNC_BUILD) && idx_ok) |=> (state_reg == ST_SETUP))
        else $error("accepted build transaction did not start the sequencer");

    a_last_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.last_of_run) |-> (out_data.fog_level == 6'(FOG_LEVELS - 1)))
        else $error("end of run flagged on a level other than the last");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, out_data.mapped_index} < ENTRIES_N))
        else $error("mapped index lies outside the palette");

    a_scan_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg != ST_SCAN) && $past(state_reg != ST_SCAN)) |-> !s2_vld_reg)
        else $error("scan pipeline active outside the palette scan");

endmodule
